FILE: src/sam_pkg.sv
// Shared types and constants for the suffix automaton matcher.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package sam_pkg;

	// Capacity of the automaton and the alphabet.
	localparam int MAX_TEXT   = 256;
	localparam int MAX_STATES = 512;
	localparam int ALPHABET   = 256;

	// Derived widths.
	localparam int ST_W   = $clog2(MAX_STATES);
	localparam int USED_W = $clog2(MAX_STATES + 1);
	localparam int LEN_W  = $clog2(MAX_TEXT + 1);
	localparam int A_W    = $clog2(ALPHABET);
	localparam int TR_AW  = ST_W + A_W;

	// Fixed field widths of the request and the result.
	localparam int SYM_W = 8;
	localparam int ML_W  = 9;
	localparam int TOT_W = 10;
	localparam int PL_W  = 9;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam logic PADDR_IDX_PATLEN = 1'b0;
	localparam logic [PL_W-1:0] PATLEN_RESET = PL_W'(1);

	// Request command codes.
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_MATCH  = 1'b1;

	typedef struct packed {
		logic             command;
		logic [SYM_W-1:0] symbol;
		logic             pattern_start;
	} sam_req_t;

	typedef struct packed {
		logic [ML_W-1:0]  match_length;
		logic             full_match;
		logic             store_full;
		logic [TOT_W-1:0] state_total;
	} sam_res_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR_ROW,
		OP_ROOT_LEN,
		OP_NEW_STATE,
		OP_RD_TP,
		OP_WR_TP_CUR,
		OP_LINK_CUR_ZERO,
		OP_RD_LENP,
		OP_RD_LENQ,
		OP_LINK_CUR_Q,
		OP_CLONE,
		OP_COPY,
		OP_WR_TP_CL,
		OP_LINK_Q_CL,
		OP_LINK_CUR_CL,
		OP_FINISH,
		OP_REPORT,
		OP_DROP,
		OP_RD_W,
		OP_W_STEP,
		OP_W_ROOT,
		OP_W_LINK,
		OP_W_LEN
	} sam_op_t;

	typedef struct packed {
		logic    load;
		sam_op_t op;
	} sam_cmd_t;

	typedef struct packed {
		logic is_match;
		logic sym_ok;
		logic room_ok;
		logic cnt_last;
		logic tr_nz;
		logic tr_eq_q;
		logic p_zero;
		logic ws_zero;
		logic w_hit;
		logic lens_eq;
	} sam_stat_t;

endpackage

FILE: src/sam_dp.sv
// Datapath of the suffix automaton matcher: transition, length and link memories,
// the construction and walk registers, and the result register. Depends on sam_pkg.
module sam_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  sam_pkg::sam_cmd_t  cmd,
	input  sam_pkg::sam_req_t  request,
	input  logic [8:0]         pattern_length,
	output sam_pkg::sam_stat_t stat,
	output logic               done,
	output sam_pkg::sam_res_t  result
);
	import sam_pkg::*;

	// Memories.
	logic [ST_W-1:0]  tr_mem [2**TR_AW];
	logic [LEN_W-1:0] len_mem [MAX_STATES];
	logic [ST_W-1:0]  link_mem [MAX_STATES];

	logic [ST_W-1:0]  tr_rd_q;
	logic [LEN_W-1:0] len_rd_q;
	logic [ST_W-1:0]  link_rd_q;

	// Request and construction registers.
	logic             cmd_q;
	logic [SYM_W-1:0] sym_q;
	logic [ST_W-1:0]  p_q, q_q, cur_q, cl_q, last_q, ws_q;
	logic [LEN_W-1:0] last_len_q, cur_len_q, lenp_q, wl_q;
	logic [USED_W-1:0] used_q;
	logic [A_W-1:0]   cnt_q, wcnt_q;
	logic             wr_pend_q;
	logic             done_q;
	sam_res_t         res_q;

	// Memory port controls.
	logic              tr_we, tr_re;
	logic [TR_AW-1:0]  tr_wa, tr_ra;
	logic [ST_W-1:0]   tr_wd;
	logic              len_we, len_re;
	logic [ST_W-1:0]   len_wa, len_ra;
	logic [LEN_W-1:0]  len_wd;
	logic              link_we, link_re;
	logic [ST_W-1:0]   link_wa, link_ra;
	logic [ST_W-1:0]   link_wd;
	logic [A_W-1:0]    sym_idx;
	logic [ST_W-1:0]   new_idx;

	assign sym_idx = sym_q[A_W-1:0];
	assign new_idx = used_q[ST_W-1:0];

	// Status toward the controller.
	always_comb begin
		stat.is_match = (cmd_q == CMD_MATCH);
		stat.sym_ok   = (int'(sym_q) < ALPHABET);
		stat.room_ok  = (int'(used_q) + 2 <= MAX_STATES) && (int'(last_len_q) < MAX_TEXT);
		stat.cnt_last = (cnt_q == A_W'(ALPHABET - 1));
		stat.tr_nz    = (tr_rd_q != '0);
		stat.tr_eq_q  = (tr_rd_q == q_q);
		stat.p_zero   = (p_q == '0);
		stat.ws_zero  = (ws_q == '0);
		stat.w_hit    = stat.sym_ok && (tr_rd_q != '0);
		stat.lens_eq  = ((LEN_W+1)'(lenp_q) + (LEN_W+1)'(1)) == (LEN_W+1)'(len_rd_q);
	end

	// Transition memory port selection.
	always_comb begin
		tr_we = 1'b0;
		tr_wa = {p_q, sym_idx};
		tr_wd = cur_q;
		tr_re = 1'b0;
		tr_ra = {p_q, sym_idx};
		case (cmd.op)
			OP_CLR_ROW: begin
				tr_we = 1'b1;
				tr_wa = {cur_q, cnt_q};
				tr_wd = '0;
			end
			OP_WR_TP_CUR: begin
				tr_we = 1'b1;
			end
			OP_WR_TP_CL: begin
				tr_we = 1'b1;
				tr_wd = cl_q;
			end
			default: begin
				// A copied entry is written in the cycle after its read.
				if (wr_pend_q) begin
					tr_we = 1'b1;
					tr_wa = {cl_q, wcnt_q};
					tr_wd = tr_rd_q;
				end
			end
		endcase
		case (cmd.op)
			OP_RD_TP: tr_re = 1'b1;
			OP_RD_W: begin
				tr_re = 1'b1;
				tr_ra = {ws_q, sym_idx};
			end
			OP_COPY: begin
				tr_re = 1'b1;
				tr_ra = {q_q, cnt_q};
			end
			default: tr_re = 1'b0;
		endcase
	end

	// Length and link memory port selection.
	always_comb begin
		len_we  = 1'b0;
		len_wa  = new_idx;
		len_wd  = last_len_q + LEN_W'(1);
		len_re  = 1'b0;
		len_ra  = p_q;
		link_we = 1'b0;
		link_wa = cur_q;
		link_wd = '0;
		link_re = 1'b0;
		link_ra = p_q;
		case (cmd.op)
			OP_ROOT_LEN: begin
				len_we = 1'b1;
				len_wa = '0;
				len_wd = '0;
			end
			OP_NEW_STATE: len_we = 1'b1;
			OP_CLONE: begin
				len_we  = 1'b1;
				len_wd  = lenp_q + LEN_W'(1);
				link_we = 1'b1;
				link_wa = new_idx;
				link_wd = link_rd_q;
			end
			OP_RD_TP: link_re = 1'b1;
			OP_RD_W: begin
				link_re = 1'b1;
				link_ra = ws_q;
			end
			OP_RD_LENP: len_re = 1'b1;
			OP_RD_LENQ: begin
				len_re  = 1'b1;
				len_ra  = q_q;
				link_re = 1'b1;
				link_ra = q_q;
			end
			OP_W_LINK: begin
				len_re = 1'b1;
				len_ra = link_rd_q;
			end
			OP_LINK_CUR_ZERO: link_we = 1'b1;
			OP_LINK_CUR_Q: begin
				link_we = 1'b1;
				link_wd = q_q;
			end
			OP_LINK_Q_CL: begin
				link_we = 1'b1;
				link_wa = q_q;
				link_wd = cl_q;
			end
			OP_LINK_CUR_CL: begin
				link_we = 1'b1;
				link_wd = cl_q;
			end
			default: len_we = 1'b0;
		endcase
	end

	// Memory arrays with registered read data.
	always_ff @(posedge clk) begin
		if (tr_we)
			tr_mem[tr_wa] <= tr_wd;
		if (tr_re)
			tr_rd_q <= tr_mem[tr_ra];
	end

	always_ff @(posedge clk) begin
		if (len_we)
			len_mem[len_wa] <= len_wd;
		if (len_re)
			len_rd_q <= len_mem[len_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		if (link_re)
			link_rd_q <= link_mem[link_ra];
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= request.command;
			sym_q <= request.symbol;
		end
	end

	// Construction, walk and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q        <= '0;
			q_q        <= '0;
			cur_q      <= '0;
			cl_q       <= '0;
			last_q     <= '0;
			ws_q       <= '0;
			last_len_q <= '0;
			cur_len_q  <= '0;
			lenp_q     <= '0;
			wl_q       <= '0;
			used_q     <= USED_W'(1);
			cnt_q      <= '0;
			wcnt_q     <= '0;
			wr_pend_q  <= 1'b0;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			wr_pend_q <= (cmd.op == OP_COPY);
			done_q    <= 1'b0;
			if (cmd.load && request.command == CMD_MATCH && request.pattern_start) begin
				ws_q <= '0;
				wl_q <= '0;
			end
			case (cmd.op)
				OP_CLR_ROW: cnt_q <= cnt_q + A_W'(1);
				OP_NEW_STATE: begin
					cur_q     <= new_idx;
					cur_len_q <= last_len_q + LEN_W'(1);
					used_q    <= used_q + USED_W'(1);
					p_q       <= last_q;
					cnt_q     <= '0;
				end
				OP_WR_TP_CUR, OP_WR_TP_CL: p_q <= link_rd_q;
				OP_RD_LENP: q_q <= tr_rd_q;
				OP_RD_LENQ: lenp_q <= len_rd_q;
				OP_CLONE: begin
					cl_q   <= new_idx;
					used_q <= used_q + USED_W'(1);
					cnt_q  <= '0;
				end
				OP_COPY: begin
					wcnt_q <= cnt_q;
					cnt_q  <= cnt_q + A_W'(1);
				end
				OP_W_STEP: begin
					ws_q <= tr_rd_q;
					wl_q <= wl_q + LEN_W'(1);
				end
				OP_W_ROOT: wl_q <= '0;
				OP_W_LINK: ws_q <= link_rd_q;
				OP_W_LEN: wl_q <= len_rd_q;
				OP_FINISH, OP_REPORT, OP_DROP: begin
					if (cmd.op == OP_FINISH) begin
						last_q     <= cur_q;
						last_len_q <= cur_len_q;
					end
					done_q                <= 1'b1;
					res_q.match_length    <= ML_W'(wl_q);
					res_q.full_match      <= (int'(wl_q) == int'(pattern_length));
					res_q.store_full      <= (cmd.op == OP_DROP);
					res_q.state_total     <= TOT_W'(used_q);
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: src/sam_ctrl.sv
// Controller of the suffix automaton matcher: sequences appends, clones and match
// walks by issuing datapath operations. Depends on sam_pkg.
module sam_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sam_pkg::sam_stat_t stat,
	output sam_pkg::sam_cmd_t  cmd,
	output logic               busy
);
	import sam_pkg::*;

	typedef enum logic [4:0] {
		S_INIT_CLR, S_INIT_LEN, S_IDLE, S_CHECK, S_NEW, S_CLR_ROW,
		S_A_RD, S_A_DEC, S_A_WR, S_LCZ, S_LENP, S_LENQ, S_CMP, S_LCQ,
		S_CLONE, S_COPY, S_R_RD, S_R_DEC, S_R_WR, S_LQ, S_LC, S_FIN,
		S_REPORT, S_DROP, S_W_RD, S_W_DEC, S_W_STEP, S_W_ROOT, S_W_LINK, S_W_LEN
	} state_t;

	state_t  state_q, state_d;
	sam_op_t op_q, op_d;
	logic    busy_q;

	// Operation issued in each state.
	function automatic sam_op_t op_of(input state_t s);
		sam_op_t o;
		unique case (s)
			S_INIT_CLR, S_CLR_ROW: o = OP_CLR_ROW;
			S_INIT_LEN:            o = OP_ROOT_LEN;
			S_NEW:                 o = OP_NEW_STATE;
			S_A_RD, S_R_RD:        o = OP_RD_TP;
			S_A_WR:                o = OP_WR_TP_CUR;
			S_LCZ:                 o = OP_LINK_CUR_ZERO;
			S_LENP:                o = OP_RD_LENP;
			S_LENQ:                o = OP_RD_LENQ;
			S_LCQ:                 o = OP_LINK_CUR_Q;
			S_CLONE:               o = OP_CLONE;
			S_COPY:                o = OP_COPY;
			S_R_WR:                o = OP_WR_TP_CL;
			S_LQ:                  o = OP_LINK_Q_CL;
			S_LC:                  o = OP_LINK_CUR_CL;
			S_FIN:                 o = OP_FINISH;
			S_REPORT:              o = OP_REPORT;
			S_DROP:                o = OP_DROP;
			S_W_RD:                o = OP_RD_W;
			S_W_STEP:              o = OP_W_STEP;
			S_W_ROOT:              o = OP_W_ROOT;
			S_W_LINK:              o = OP_W_LINK;
			S_W_LEN:               o = OP_W_LEN;
			default:               o = OP_NONE;
		endcase
		return o;
	endfunction

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT_CLR: if (stat.cnt_last) state_d = S_INIT_LEN;
			S_INIT_LEN: state_d = S_IDLE;
			S_IDLE:     if (start) state_d = S_CHECK;
			S_CHECK: begin
				if (stat.is_match)
					state_d = S_W_RD;
				else if (!stat.sym_ok)
					state_d = S_REPORT;
				else if (!stat.room_ok)
					state_d = S_DROP;
				else
					state_d = S_NEW;
			end
			S_NEW:     state_d = S_CLR_ROW;
			S_CLR_ROW: if (stat.cnt_last) state_d = S_A_RD;
			S_A_RD:    state_d = S_A_DEC;
			S_A_DEC:   state_d = stat.tr_nz ? S_LENP : S_A_WR;
			S_A_WR:    state_d = stat.p_zero ? S_LCZ : S_A_RD;
			S_LCZ:     state_d = S_FIN;
			S_LENP:    state_d = S_LENQ;
			S_LENQ:    state_d = S_CMP;
			S_CMP:     state_d = stat.lens_eq ? S_LCQ : S_CLONE;
			S_LCQ:     state_d = S_FIN;
			S_CLONE:   state_d = S_COPY;
			S_COPY:    if (stat.cnt_last) state_d = S_R_RD;
			S_R_RD:    state_d = S_R_DEC;
			S_R_DEC:   state_d = stat.tr_eq_q ? S_R_WR : S_LQ;
			S_R_WR:    state_d = stat.p_zero ? S_LQ : S_R_RD;
			S_LQ:      state_d = S_LC;
			S_LC:      state_d = S_FIN;
			S_FIN, S_REPORT, S_DROP: state_d = S_IDLE;
			S_W_RD:    state_d = S_W_DEC;
			S_W_DEC: begin
				if (stat.w_hit)
					state_d = S_W_STEP;
				else if (stat.ws_zero)
					state_d = S_W_ROOT;
				else
					state_d = S_W_LINK;
			end
			S_W_STEP, S_W_ROOT: state_d = S_REPORT;
			S_W_LINK: state_d = S_W_LEN;
			S_W_LEN:  state_d = S_W_RD;
			default:  state_d = S_IDLE;
		endcase
		op_d = op_of(state_d);
	end

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_CLR;
			op_q    <= OP_CLR_ROW;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign cmd.load = start && !busy_q;
	assign cmd.op   = op_q;
	assign busy     = busy_q;

endmodule

FILE: src/suffix_automaton_matcher.sv
// Suffix automaton matcher top level: request/result ports, APB register, and the
// controller and datapath. Depends on sam_pkg, sam_ctrl and sam_dp.
//
// Usage. A request is taken at a rising edge with start high and busy low. An
// append request (command 0) adds one text byte to the automaton; a match request
// (command 1) feeds one pattern byte to the match walk, with pattern_start
// returning the walk to the root first. Every request yields one result, shown
// for one cycle with done high; the receiver cannot stall, so it must take it.
// A match request follows the walk state's transition on a hit; on a miss it
// falls back along a suffix link and tries again, or stops at the root. An
// append clears the new state's row one entry per cycle, then writes transitions
// along the suffix chain until it runs off the root or stops on an existing
// transition, where a clone may copy that state's row and redirect links. A
// dropped append only reports its result. Busy falls in the result cycle, so the
// next request can be taken at the edge that ends it.
// After reset the block clears the root's transition row with busy high; APB
// writes are taken throughout. pattern_length lives at address 0.
module suffix_automaton_matcher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  sam_pkg::sam_req_t                    request,
	output logic                                 busy,
	output logic                                 done,
	output sam_pkg::sam_res_t                    result,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sam_pkg::PADDR_W-1:0]          paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import sam_pkg::*;

	sam_cmd_t        cmd;
	sam_stat_t       stat;
	logic [PL_W-1:0] patlen_q;

	// Pattern length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patlen_q <= PATLEN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == PADDR_IDX_PATLEN) begin
			patlen_q <= pwdata[PL_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == PADDR_IDX_PATLEN) ? 32'(patlen_q) : '0;

	sam_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	sam_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.request        (request),
		.pattern_length (patlen_q),
		.stat           (stat),
		.done           (done),
		.result         (result)
	);

endmodule

FILE: src/sam_checker.sv
// Port-level checker for the suffix automaton matcher, bound to the top level.
// Depends on sam_pkg.
module sam_port_assertions (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input sam_pkg::sam_res_t result
);
	import sam_pkg::*;

	// An accepted request makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after accepted request");

	// A result appears only once the block is idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// Results never come in back-to-back cycles.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("results on consecutive cycles");

	// The root always exists.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.state_total != '0) else $error("zero state count");

endmodule

bind suffix_automaton_matcher sam_port_assertions u_sam_port_assertions (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

FILE: tb/sam_checker.sv
// Checker for the suffix automaton matcher: watches the request, result and APB channels.
// Keeps its own automaton and match walk to predict every result. Depends on sam_pkg.
`timescale 1ns / 1ps

module sam_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  sam_pkg::sam_req_t           request,
	input  logic                        done,
	input  sam_pkg::sam_res_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sam_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	output int                          pending,
	output int                          errors,
	output int                          result_count,
	output int                          full_match_count,
	output int                          dropped_count,
	output int                          clone_count
);
	import sam_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_PATLEN = PADDR_W'(4 * PADDR_IDX_PATLEN);

	// Shadow automaton and walk.
	logic [LEN_W-1:0]  model_len [MAX_STATES];
	logic [ST_W-1:0]   model_link [MAX_STATES];
	logic [ST_W-1:0]   model_next [MAX_STATES * ALPHABET];
	logic [ST_W-1:0]   model_last;
	logic [USED_W-1:0] model_used;
	logic [ST_W-1:0]   walk_st;
	logic [LEN_W-1:0]  walk_len;
	logic [PL_W-1:0]   model_patlen;
	sam_res_t          expected_results[$];

	assign pending = expected_results.size();

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int row_idx(input logic [ST_W-1:0] s, input logic [A_W-1:0] c);
		return int'({s, c});
	endfunction

	// Extends the shadow automaton by one symbol; returns 1 when there is no room.
	function automatic logic extend_text(input logic [A_W-1:0] c);
		logic [ST_W-1:0] cur, p, q, cl;
		logic have_p, walking;
		if (int'(model_used) + 2 > MAX_STATES || int'(model_len[model_last]) >= MAX_TEXT)
			return 1'b1;
		cur = model_used[ST_W-1:0];
		model_used++;
		model_len[cur] = model_len[model_last] + 1'b1;
		model_link[cur] = '0;
		for (int a = 0; a < ALPHABET; a++)
			model_next[row_idx(cur, A_W'(a))] = '0;
		// Add transitions to the new state along the suffix chain of the old last state.
		p = model_last;
		have_p = 1'b1;
		walking = 1'b1;
		while (walking) begin
			if (model_next[row_idx(p, c)] != '0) begin
				walking = 1'b0;
			end else begin
				model_next[row_idx(p, c)] = cur;
				if (p == '0) begin
					have_p = 1'b0;
					walking = 1'b0;
				end else begin
					p = model_link[p];
				end
			end
		end
		if (have_p) begin
			q = model_next[row_idx(p, c)];
			if (model_len[p] + 1'b1 == model_len[q]) begin
				model_link[cur] = q;
			end else begin
				// Lengths disagree: split q by a clone carrying its whole row.
				clone_count++;
				cl = model_used[ST_W-1:0];
				model_used++;
				for (int a = 0; a < ALPHABET; a++)
					model_next[row_idx(cl, A_W'(a))] = model_next[row_idx(q, A_W'(a))];
				model_len[cl] = model_len[p] + 1'b1;
				model_link[cl] = model_link[q];
				walking = 1'b1;
				while (walking) begin
					if (model_next[row_idx(p, c)] != q) begin
						walking = 1'b0;
					end else begin
						model_next[row_idx(p, c)] = cl;
						if (p == '0)
							walking = 1'b0;
						else
							p = model_link[p];
					end
				end
				model_link[q] = cl;
				model_link[cur] = cl;
			end
		end
		model_last = cur;
		return 1'b0;
	endfunction

	// Advances the match walk by one pattern symbol, falling back along suffix links.
	function automatic void advance_walk(input logic [A_W-1:0] c);
		forever begin
			if (model_next[row_idx(walk_st, c)] != '0) begin
				walk_st = model_next[row_idx(walk_st, c)];
				walk_len++;
				return;
			end
			if (walk_st == '0) begin
				walk_len = '0;
				return;
			end
			walk_st = model_link[walk_st];
			walk_len = model_len[walk_st];
		end
	endfunction

	function automatic sam_res_t predict_result(input sam_req_t rq);
		sam_res_t r;
		logic dropped;
		dropped = 1'b0;
		if (rq.command == CMD_APPEND) begin
			dropped = extend_text(rq.symbol);
		end else begin
			if (rq.pattern_start) begin
				walk_st = '0;
				walk_len = '0;
			end
			advance_walk(rq.symbol);
		end
		r.match_length = walk_len;
		r.full_match = (walk_len == model_patlen);
		r.store_full = dropped;
		r.state_total = model_used;
		return r;
	endfunction

	// Watch the channels: compare results, follow register writes, predict requests.
	always @(posedge clk or negedge arst_n) begin
		sam_res_t want;
		if (!arst_n) begin
			for (int s = 0; s < MAX_STATES; s++) begin
				model_len[s] = '0;
				model_link[s] = '0;
			end
			for (int i = 0; i < MAX_STATES * ALPHABET; i++)
				model_next[i] = '0;
			model_last = '0;
			model_used = USED_W'(1);
			walk_st = '0;
			walk_len = '0;
			model_patlen = PATLEN_RESET;
			expected_results.delete();
		end else begin
			if (done) begin
				result_count++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request outstanding", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (result.match_length != want.match_length)
						report_mismatch("match_length", int'(result.match_length),
							int'(want.match_length));
					if (result.full_match != want.full_match)
						report_mismatch("full_match", int'(result.full_match),
							int'(want.full_match));
					if (result.store_full != want.store_full)
						report_mismatch("store_full", int'(result.store_full),
							int'(want.store_full));
					if (result.state_total != want.state_total)
						report_mismatch("state_total", int'(result.state_total),
							int'(want.state_total));
					if (want.full_match)
						full_match_count++;
					if (want.store_full)
						dropped_count++;
				end
			end
			if (psel && penable && pready && paddr == ADDR_PATLEN) begin
				if (pwrite)
					model_patlen = pwdata[PL_W-1:0];
				else if (prdata != 32'(model_patlen))
					report_mismatch("pattern_length readback", int'(prdata),
						int'(model_patlen));
			end
			if (start && !busy)
				expected_results.insert(expected_results.size(), predict_result(request));
		end
	end

endmodule

FILE: tb/tb.sv
// Testbench top for the suffix automaton matcher: clock, reset, stimulus and verdict.
// Depends on sam_pkg, suffix_automaton_matcher and sam_checker.
`timescale 1ns / 1ps

module tb;
	import sam_pkg::*;

	localparam int LIMIT = 12000000;
	localparam int RANDOM_ITEMS = 1700;
	localparam logic [PADDR_W-1:0] ADDR_PATLEN = PADDR_W'(4 * PADDR_IDX_PATLEN);

	logic               clk;
	logic               arst_n;
	logic               start;
	sam_req_t           request;
	logic               busy;
	logic               done;
	sam_res_t           result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 pending;
	int                 errors;
	int                 result_count;
	int                 full_match_count;
	int                 dropped_count;
	int                 clone_count;
	int                 cycles;
	int                 sent;
	int                 no_gap_left;
	logic [7:0]         text [MAX_TEXT];
	int                 text_len;

	suffix_automaton_matcher i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request), .busy(busy),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	sam_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pending(pending), .errors(errors), .result_count(result_count),
		.full_match_count(full_match_count), .dropped_count(dropped_count),
		.clone_count(clone_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Gap before a request: runs of back-to-back requests alternate with random gaps.
	function automatic int draw_gap();
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			no_gap_left = $urandom_range(10, 40);
		return $urandom_range(0, 16);
	endfunction

	// Presents one request and returns at the edge that accepts it.
	task automatic send_request(input logic cmd, input logic [7:0] sym, input logic pstart);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= '{command: cmd, symbol: sym, pattern_start: pstart};
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
		sent++;
		if (cmd == CMD_APPEND && text_len < MAX_TEXT) begin
			text[text_len] = sym;
			text_len++;
		end
	endtask

	// Holds the sender until every expected result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes pattern_length, then reads it back.
	task automatic set_pattern_length(input int value);
		drain();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_PATLEN; pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0;
		@(posedge clk);
	endtask

	// Feeds a pattern taken from the text, with the odd symbol corrupted.
	task automatic send_pattern(input int from, input int count);
		logic [7:0] sym;
		for (int k = 0; k < count; k++) begin
			sym = text[(from + k) % MAX_TEXT];
			if ($urandom_range(0, 15) == 0)
				sym = 8'($urandom);
			send_request(CMD_MATCH, sym, k == 0);
		end
	endtask

	initial begin
		int from, count;
		int phase_values[6];
		phase_values = '{3, 0, 256, 511, 1, 7};
		cycles = 0; sent = 0; no_gap_left = 0; text_len = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: walking an empty automaton falls off the root.
		send_request(CMD_MATCH, 8'h00, 1'b1);
		send_request(CMD_MATCH, 8'hFF, 1'b0);
		// Text with repeats so that clones occur, extreme symbols included.
		send_request(CMD_APPEND, 8'h00, 1'b1);
		send_request(CMD_APPEND, 8'hFF, 1'b0);
		send_request(CMD_APPEND, 8'h00, 1'b0);
		send_request(CMD_APPEND, 8'hFF, 1'b0);
		send_request(CMD_APPEND, 8'hFF, 1'b1);
		send_request(CMD_APPEND, 8'h00, 1'b0);
		// Matches: hit at the default length, longer runs, misses and restarts.
		send_request(CMD_MATCH, 8'h00, 1'b1);
		send_request(CMD_MATCH, 8'hFF, 1'b0);
		send_request(CMD_MATCH, 8'hFF, 1'b0);
		send_request(CMD_MATCH, 8'h00, 1'b0);
		send_request(CMD_MATCH, 8'h5A, 1'b0);
		send_request(CMD_MATCH, 8'hFF, 1'b1);
		send_request(CMD_MATCH, 8'hFF, 1'b0);
		send_request(CMD_MATCH, 8'h00, 1'b0);
		send_request(CMD_MATCH, 8'hA5, 1'b1);
		set_pattern_length(0);
		send_request(CMD_MATCH, 8'h5A, 1'b1);
		send_request(CMD_MATCH, 8'h00, 1'b0);

		// Random: appends mixed with pattern walks and stray matches, over six pattern lengths.
		for (int ph = 0; ph < 6; ph++) begin
			set_pattern_length(phase_values[ph]);
			while (sent < 20 + (ph + 1) * RANDOM_ITEMS / 6) begin
				if ($urandom_range(0, 99) < 30) begin
					if ($urandom_range(0, 9) < 7)
						send_request(CMD_APPEND, 8'($urandom_range(0, 3)), 1'($urandom));
					else
						send_request(CMD_APPEND, 8'($urandom), 1'($urandom));
				end else if (text_len > 0 && $urandom_range(0, 9) < 8) begin
					from = $urandom_range(0, text_len - 1);
					count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, text_len - from)
						: $urandom_range(1, 8);
					send_pattern(from, count);
				end else begin
					send_request(CMD_MATCH, 8'($urandom), 1'($urandom));
				end
			end
		end

		// Directed: the whole text as a pattern at pattern length MAX_TEXT.
		set_pattern_length(MAX_TEXT);
		for (int k = 0; k < text_len; k++)
			send_request(CMD_MATCH, text[k], k == 0);
		send_request(CMD_APPEND, 8'h01, 1'b0);

		drain();
		repeat (50) @(posedge clk);
		$display("Sent %0d requests, %0d text bytes; %0d results, %0d clones predicted.",
			sent, text_len, result_count, clone_count);
		$display("Full matches seen: %0d, dropped appends: %0d.", full_match_count,
			dropped_count);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
src/sam_pkg.sv
src/sam_dp.sv
src/sam_ctrl.sv
src/suffix_automaton_matcher.sv
src/sam_checker.sv
tb/sam_checker.sv
tb/tb.sv
